// ----- design/psimd_pkg.sv -----
`default_nettype none
package psimd_pkg;

    localparam int BYTE_W     = 8;
    localparam int HALF_W     = 16;
    localparam int BYTE_LANES = 4;
    localparam int HALF_LANES = 2;

    // Operation code ranges and single codes
    localparam logic [5:0] OP_ADDSUB_LO = 6'd0;
    localparam logic [5:0] OP_ADDSUB_HI = 6'd7;
    localparam logic [5:0] OP_EXCH_LO   = 6'd8;
    localparam logic [5:0] OP_EXCH_HI   = 6'd15;
    localparam logic [5:0] OP_HALVE_LO  = 6'd16;
    localparam logic [5:0] OP_HALVE_HI  = 6'd23;
    localparam logic [5:0] OP_SAT_LO    = 6'd24;
    localparam logic [5:0] OP_SAT_HI    = 6'd31;
    localparam logic [5:0] OP_USAD8     = 6'd32;
    localparam logic [5:0] OP_SEL       = 6'd33;

    typedef enum logic [1:0] {
        MODE_GE,
        MODE_HALF,
        MODE_SAT,
        MODE_ABS
    } lane_mode_t;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_BYTE,
        KIND_HALF,
        KIND_EXCH,
        KIND_SAD,
        KIND_SEL
    } op_kind_t;

    typedef struct packed {
        lane_mode_t mode;
        logic       sgn;
        logic       add;
    } lane_ctrl_t;

    typedef struct packed {
        op_kind_t   kind;
        lane_ctrl_t lane;
        logic       ge_wr;
    } op_ctrl_t;

    // Bit 0: signed, bit 1: subtract (or sub-add for exchange), bit 2: halfword or halving
    function automatic op_ctrl_t decode_op(input logic [5:0] op);
        op_ctrl_t c;
        c.kind      = op[2] ? KIND_HALF : KIND_BYTE;
        c.lane.sgn  = op[0];
        c.lane.add  = ~op[1];
        c.lane.mode = MODE_GE;
        c.ge_wr     = 1'b0;
        case (op) inside
            [OP_ADDSUB_LO:OP_ADDSUB_HI]:
            begin
                c.ge_wr = 1'b1;
            end
            [OP_EXCH_LO:OP_EXCH_HI]:
            begin
                c.kind      = KIND_EXCH;
                c.lane.add  = op[1];
                c.lane.mode = op[2] ? MODE_HALF : MODE_GE;
                c.ge_wr     = ~op[2];
            end
            [OP_HALVE_LO:OP_HALVE_HI]:
            begin
                c.lane.mode = MODE_HALF;
            end
            [OP_SAT_LO:OP_SAT_HI]:
            begin
                c.lane.mode = MODE_SAT;
            end
            OP_USAD8:
            begin
                c.kind      = KIND_SAD;
                c.lane.sgn  = 1'b0;
                c.lane.add  = 1'b0;
                c.lane.mode = MODE_ABS;
            end
            OP_SEL:
            begin
                c.kind = KIND_SEL;
            end
            default:
            begin
                c.kind = KIND_NONE;
            end
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- design/psimd_lane.sv -----
`default_nettype none
module psimd_lane #(
    parameter int W = 8
) (
    input  wire logic [W-1:0]         x,
    input  wire logic [W-1:0]         y,
    input  wire psimd_pkg::lane_ctrl_t ctrl,
    output logic      [W-1:0]         value,
    output logic                      flag
);
    import psimd_pkg::*;

    localparam int RW = W + 2;

    logic [RW-1:0] xe;
    logic [RW-1:0] ye;
    logic [RW-1:0] r;
    logic [RW-1:0] r_abs;
    logic          neg;

    assign xe    = {{2{ctrl.sgn & x[W-1]}}, x};
    assign ye    = {{2{ctrl.sgn & y[W-1]}}, y};
    assign r     = ctrl.add ? (xe + ye) : (xe - ye);
    assign neg   = r[RW-1];
    assign r_abs = {RW{1'b0}} - r;

    // GE: signed or unsigned-subtract on a non-negative result, unsigned add on carry out
    assign flag = ctrl.sgn ? ~neg : (ctrl.add ? r[W] : ~neg);

    always_comb
    begin
        case (ctrl.mode)
            MODE_GE:
            begin
                value = r[W-1:0];
            end
            MODE_HALF:
            begin
                value = r[W:1];
            end
            MODE_SAT:
            begin
                if (ctrl.sgn)
                begin
                    if (r[W] != r[W-1])
                        value = r[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                    else
                        value = r[W-1:0];
                end
                else if (ctrl.add)
                begin
                    value = r[W] ? {W{1'b1}} : r[W-1:0];
                end
                else
                begin
                    value = neg ? {W{1'b0}} : r[W-1:0];
                end
            end
            MODE_ABS:
            begin
                value = neg ? r_abs[W-1:0] : r[W-1:0];
            end
            default:
            begin
                value = r[W-1:0];
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- design/psimd_merge.sv -----
`default_nettype none
module psimd_merge (
    input  wire psimd_pkg::op_ctrl_t ctrl,
    input  wire logic [3:0][7:0]     byte_val,
    input  wire logic [3:0]          byte_flag,
    input  wire logic [1:0][15:0]    half_val,
    input  wire logic [1:0]          half_flag,
    input  wire logic [31:0]         sel_a,
    input  wire logic [31:0]         sel_b,
    input  wire logic [3:0]          sel_ge,
    output logic      [31:0]         result,
    output logic      [3:0]          ge_out,
    output logic                     ge_written
);
    import psimd_pkg::*;

    logic [9:0]  sad;
    logic [31:0] sel_word;
    logic [3:0]  ge_all;

    assign sad = {2'b00, byte_val[0]} + {2'b00, byte_val[1]}
               + {2'b00, byte_val[2]} + {2'b00, byte_val[3]};

    always_comb
    begin
        for (int i = 0; i < BYTE_LANES; i++)
            sel_word[i*BYTE_W +: BYTE_W] = sel_ge[i] ? sel_a[i*BYTE_W +: BYTE_W]
                                                     : sel_b[i*BYTE_W +: BYTE_W];
    end

    // Halfword lanes drive both GE bits of their pair of bytes
    assign ge_all = (ctrl.kind == KIND_BYTE) ? byte_flag
                  : {{2{half_flag[1]}}, {2{half_flag[0]}}};

    always_comb
    begin
        case (ctrl.kind)
            KIND_BYTE:              result = byte_val;
            KIND_HALF, KIND_EXCH:   result = half_val;
            KIND_SAD:               result = {22'd0, sad};
            KIND_SEL:               result = sel_word;
            default:                result = 32'd0;
        endcase
    end

    assign ge_out     = ctrl.ge_wr ? ge_all : 4'd0;
    assign ge_written = ctrl.ge_wr;

endmodule
`default_nettype wire

// ----- design/packed_simd_add_sub_unit_top.sv -----
`default_nettype none
// Packed SIMD add/subtract unit: an accepted item passes through the lane stage register and then the output register.
// Throughput: one item per cycle while out_stall is low; each stage advances when the one after it is empty or moving.
// in_stall rises only when both stages hold items and the output side stalls.
// Reset (rst_n, asynchronous, active low) empties both stages; payload is not cleared.
module packed_simd_add_sub_unit_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [5:0]  operation,
    input  wire logic [31:0] operand_a,
    input  wire logic [31:0] operand_b,
    input  wire logic [3:0]  ge_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      result,
    output logic [3:0]       ge_out,
    output logic             ge_written
);
    import psimd_pkg::*;

    // ---------------------------------------------------------------
    // Decode and lane control
    // ---------------------------------------------------------------
    op_ctrl_t   dec;
    lane_ctrl_t half_ctrl [HALF_LANES];
    logic       exch;

    assign dec  = decode_op(operation);
    assign exch = (dec.kind == KIND_EXCH);

    // Exchange ops: the low lane takes the decoded direction, the high lane the opposite
    always_comb
    begin
        half_ctrl[0]     = dec.lane;
        half_ctrl[1]     = dec.lane;
        half_ctrl[1].add = exch ? ~dec.lane.add : dec.lane.add;
    end

    // ---------------------------------------------------------------
    // Parallel lanes: four byte lanes, two halfword lanes
    // ---------------------------------------------------------------
    logic [3:0][7:0]  byte_val_next;
    logic [3:0]       byte_flag_next;
    logic [1:0][15:0] half_val_next;
    logic [1:0]       half_flag_next;
    logic [15:0]      half_y [HALF_LANES];

    genvar gi;
    generate
        for (gi = 0; gi < BYTE_LANES; gi++)
        begin : g_byte
            psimd_lane #(.W(BYTE_W)) u_lane (
                .x     (operand_a[gi*BYTE_W +: BYTE_W]),
                .y     (operand_b[gi*BYTE_W +: BYTE_W]),
                .ctrl  (dec.lane),
                .value (byte_val_next[gi]),
                .flag  (byte_flag_next[gi])
            );
        end
    endgenerate

    // Swap the halves of operand_b for the exchange forms
    assign half_y[0] = exch ? operand_b[31:16] : operand_b[15:0];
    assign half_y[1] = exch ? operand_b[15:0]  : operand_b[31:16];

    generate
        for (gi = 0; gi < HALF_LANES; gi++)
        begin : g_half
            psimd_lane #(.W(HALF_W)) u_lane (
                .x     (operand_a[gi*HALF_W +: HALF_W]),
                .y     (half_y[gi]),
                .ctrl  (half_ctrl[gi]),
                .value (half_val_next[gi]),
                .flag  (half_flag_next[gi])
            );
        end
    endgenerate

    // ---------------------------------------------------------------
    // Flow control: a stage advances when the one after it is empty or moving
    // ---------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic s2_advance;
    logic s1_advance;
    logic in_accept;

    assign s2_advance = ~out_valid_reg | ~out_stall;
    assign s1_advance = ~s1_valid_reg | s2_advance;
    assign in_stall   = ~s1_advance;
    assign in_accept  = in_valid & s1_advance;
    assign out_valid  = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_advance)
                s1_valid_reg <= in_valid;
            if (s2_advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // ---------------------------------------------------------------
    // Lane stage registers
    // ---------------------------------------------------------------
    op_ctrl_t         ctrl_reg;
    logic [3:0][7:0]  byte_val_reg;
    logic [3:0]       byte_flag_reg;
    logic [1:0][15:0] half_val_reg;
    logic [1:0]       half_flag_reg;
    logic [31:0]      a_reg;
    logic [31:0]      b_reg;
    logic [3:0]       ge_in_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ctrl_reg      <= dec;
            byte_val_reg  <= byte_val_next;
            byte_flag_reg <= byte_flag_next;
            half_val_reg  <= half_val_next;
            half_flag_reg <= half_flag_next;
            a_reg         <= operand_a;
            b_reg         <= operand_b;
            ge_in_reg     <= ge_in;
        end
    end

    // ---------------------------------------------------------------
    // Merge lanes into the result word and GE flags
    // ---------------------------------------------------------------
    logic [31:0] result_next;
    logic [3:0]  ge_out_next;
    logic        ge_written_next;

    psimd_merge u_merge (
        .ctrl       (ctrl_reg),
        .byte_val   (byte_val_reg),
        .byte_flag  (byte_flag_reg),
        .half_val   (half_val_reg),
        .half_flag  (half_flag_reg),
        .sel_a      (a_reg),
        .sel_b      (b_reg),
        .sel_ge     (ge_in_reg),
        .result     (result_next),
        .ge_out     (ge_out_next),
        .ge_written (ge_written_next)
    );

    // Output register: hold while the item waits, load when moving on
    logic [31:0] result_reg;
    logic [3:0]  ge_out_reg;
    logic        ge_written_reg;

    always_ff @(posedge clk)
    begin
        if (s2_advance && s1_valid_reg)
        begin
            result_reg     <= result_next;
            ge_out_reg     <= ge_out_next;
            ge_written_reg <= ge_written_next;
        end
    end

    assign result     = result_reg;
    assign ge_out     = ge_out_reg;
    assign ge_written = ge_written_reg;

`ifndef ASSERT_OFF
    a_ge_clear_when_unwritten: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !ge_written_reg) |-> (ge_out_reg == 4'd0))
        else $error("GE flags set on an item that does not write them");

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled with the output register empty");

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted item lost from the lane stage");

    a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("lane stage item not moved to an empty output register");
`endif

endmodule
`default_nettype wire
